### rtl/dpalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpalu_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned OpW   = 4;
	localparam int unsigned FlagW = 4;

	// data-processing opcodes
	localparam logic [OpW-1:0] OP_AND = 4'd0;
	localparam logic [OpW-1:0] OP_EOR = 4'd1;
	localparam logic [OpW-1:0] OP_SUB = 4'd2;
	localparam logic [OpW-1:0] OP_RSB = 4'd3;
	localparam logic [OpW-1:0] OP_ADD = 4'd4;
	localparam logic [OpW-1:0] OP_ADC = 4'd5;
	localparam logic [OpW-1:0] OP_SBC = 4'd6;
	localparam logic [OpW-1:0] OP_RSC = 4'd7;
	localparam logic [OpW-1:0] OP_TST = 4'd8;
	localparam logic [OpW-1:0] OP_TEQ = 4'd9;
	localparam logic [OpW-1:0] OP_CMP = 4'd10;
	localparam logic [OpW-1:0] OP_CMN = 4'd11;
	localparam logic [OpW-1:0] OP_ORR = 4'd12;
	localparam logic [OpW-1:0] OP_MOV = 4'd13;
	localparam logic [OpW-1:0] OP_BIC = 4'd14;
	localparam logic [OpW-1:0] OP_MVN = 4'd15;

	// flag bit positions
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	// logic unit function codes
	localparam logic [2:0] LOP_AND = 3'd0;
	localparam logic [2:0] LOP_EOR = 3'd1;
	localparam logic [2:0] LOP_ORR = 3'd2;
	localparam logic [2:0] LOP_MOV = 3'd3;
	localparam logic [2:0] LOP_BIC = 3'd4;
	localparam logic [2:0] LOP_MVN = 3'd5;

	// decoded operands, stage 1 to stage 2
	typedef struct packed {
		logic             logical;
		logic [2:0]       lop;
		logic [WordW-1:0] x;
		logic [WordW-1:0] y;
		logic             cin;
		logic             keep;
		logic             shc;
		logic             v_in;
	} dec_t;

	// raw value and adder flags, stage 2 to stage 3
	typedef struct packed {
		logic [WordW-1:0] val;
		logic             carry;
		logic             x_msb;
		logic             y_msb;
		logic             logical;
		logic             keep;
		logic             shc;
		logic             v_in;
	} exe_t;

	// final result, stage 3 to output
	typedef struct packed {
		logic [FlagW-1:0] flags;
		logic [WordW-1:0] res;
	} res_t;

endpackage

`default_nettype wire

### rtl/dpalu_operand.sv
`timescale 1ns / 1ps
`default_nettype none

module dpalu_operand
	import dpalu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OpW-1:0]   operation,
	input  wire logic [WordW-1:0] operand_n,
	input  wire logic [WordW-1:0] operand_shifted,
	input  wire logic [FlagW-1:0] flags_in,
	input  wire logic             shifter_carry,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output dec_t                  out_data
);

	logic valid_s1;
	dec_t dec;
	dec_t data_s1;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		dec         = '0;
		dec.shc     = shifter_carry;
		dec.v_in    = flags_in[FLAG_V];
		dec.keep    = 1'b1;
		dec.x       = operand_n;
		dec.y       = operand_shifted;
		unique case (operation) inside
			OP_AND, OP_TST: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_AND;
			end
			OP_EOR, OP_TEQ: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_EOR;
			end
			OP_ORR: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_ORR;
			end
			OP_MOV: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_MOV;
			end
			OP_BIC: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_BIC;
			end
			OP_MVN: begin
				dec.logical = 1'b1;
				dec.lop     = LOP_MVN;
			end
			OP_SUB, OP_CMP: begin
				dec.y   = ~operand_shifted;
				dec.cin = 1'b1;
			end
			OP_RSB: begin
				dec.x   = operand_shifted;
				dec.y   = ~operand_n;
				dec.cin = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				dec.cin = 1'b0;
			end
			OP_ADC: begin
				dec.cin = flags_in[FLAG_C];
			end
			OP_SBC: begin
				dec.y   = ~operand_shifted;
				dec.cin = flags_in[FLAG_C];
			end
			OP_RSC: begin
				dec.x   = operand_shifted;
				dec.y   = ~operand_n;
				dec.cin = flags_in[FLAG_C];
			end
			default: begin
				dec.logical = 1'b0;
			end
		endcase
		// tests and compares only set flags
		if (operation == OP_TST || operation == OP_TEQ ||
				operation == OP_CMP || operation == OP_CMN) begin
			dec.keep = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= dec;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

### rtl/dpalu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module dpalu_exec
	import dpalu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  dec_t      in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output exe_t      out_data
);

	logic             valid_s2;
	exe_t             data_s2;
	exe_t             exe;
	logic [WordW:0]   sum;
	logic [WordW-1:0] lval;

	assign in_ready = !valid_s2 || out_ready;

	// 33-bit adder, top bit is the carry out
	assign sum = {1'b0, in_data.x} + {1'b0, in_data.y} + {{WordW{1'b0}}, in_data.cin};

	always_comb begin
		case (in_data.lop)
			LOP_AND: lval = in_data.x & in_data.y;
			LOP_EOR: lval = in_data.x ^ in_data.y;
			LOP_ORR: lval = in_data.x | in_data.y;
			LOP_MOV: lval = in_data.y;
			LOP_BIC: lval = in_data.x & ~in_data.y;
			LOP_MVN: lval = ~in_data.y;
			default: lval = in_data.y;
		endcase
	end

	always_comb begin
		exe.val     = in_data.logical ? lval : sum[WordW-1:0];
		exe.carry   = sum[WordW];
		exe.x_msb   = in_data.x[WordW-1];
		exe.y_msb   = in_data.y[WordW-1];
		exe.logical = in_data.logical;
		exe.keep    = in_data.keep;
		exe.shc     = in_data.shc;
		exe.v_in    = in_data.v_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= exe;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

### rtl/dpalu_flags.sv
`timescale 1ns / 1ps
`default_nettype none

module dpalu_flags
	import dpalu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  exe_t      in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	logic valid_s3;
	res_t data_s3;
	res_t fin;
	logic ovf;

	assign in_ready = !valid_s3 || out_ready;

	// signed overflow: both addends differ in sign from the sum
	assign ovf = (in_data.x_msb ^ in_data.val[WordW-1]) &
		(in_data.y_msb ^ in_data.val[WordW-1]);

	always_comb begin
		fin.res           = in_data.keep ? in_data.val : '0;
		fin.flags[FLAG_N] = in_data.val[WordW-1];
		fin.flags[FLAG_Z] = (in_data.val == '0);
		fin.flags[FLAG_C] = in_data.logical ? in_data.shc : in_data.carry;
		fin.flags[FLAG_V] = in_data.logical ? in_data.v_in : ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= fin;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

`default_nettype wire

### rtl/arm_data_processing_alu.sv
// channel   direction  signals                  payload
// s_        in         s_tvalid/s_tready        s_tuser: operation
//                                               s_tdata: operand_n, operand_shifted,
//                                                        flags_in, shifter_carry
// m_        out        m_tvalid/m_tready        m_tdata: result, flags_out
//
// an s_ transfer reaches m_tvalid through the three pipeline registers (decode,
// adder/logic, flags); throughput is one item per cycle while m_tready is high
// arst_n clears the valid bits of all stages, payload registers are not reset
// a low m_tready holds the last stage; upper stages keep filling until every
// stage is full, then s_tready drops, so nothing is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none

module arm_data_processing_alu
	import dpalu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [3:0] operation
	input  wire logic [3:0]  s_tuser,
	// [31:0] operand_n, [63:32] operand_shifted, [67:64] flags_in,
	// [68] shifter_carry, [71:69] zero
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] result, [35:32] flags_out, [39:36] zero
	output logic [39:0]      m_tdata
);

	// stage handshakes
	logic v1, r1;
	logic v2, r2;
	dec_t d1;
	exe_t d2;
	res_t d3;

	// stage 1: opcode decode and operand steering into adder form
	dpalu_operand u_operand (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.operation       (s_tuser),
		.operand_n       (s_tdata[31:0]),
		.operand_shifted (s_tdata[63:32]),
		.flags_in        (s_tdata[67:64]),
		.shifter_carry   (s_tdata[68]),
		.out_valid       (v1),
		.out_ready       (r1),
		.out_data        (d1)
	);

	// stage 2: 33-bit add or bitwise logic
	dpalu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2)
	);

	// stage 3: nzcv, result masking for tests and compares; doubles as output register
	dpalu_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (d3)
	);

	assign m_tdata = {4'b0, d3.flags, d3.res};

endmodule

`default_nettype wire

### rtl/dpalu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dpalu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// a stalled output transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// a ready sink lets every stage advance
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// an accepted item passes the decode, adder/logic and flags registers to m_tvalid while m_tready stays high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("item did not reach output in three cycles");

	// a nonzero result is the flag value, so n and z follow it
	a_nz_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:0] != 32'd0) |-> !m_tdata[34] && (m_tdata[35] == m_tdata[31]))
		else $error("n or z flag inconsistent with result");

endmodule

bind arm_data_processing_alu dpalu_checker u_dpalu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### test/arm_data_processing_alu_tb.sv
`timescale 1ns / 1ps

module arm_data_processing_alu_tb;
	import dpalu_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned RandomItems = 600;
	localparam int unsigned ChokeCycles = 60;
	localparam int unsigned DrainCycles = 10;

	// one predicted outcome of the alu
	typedef struct {
		logic [WordW-1:0] result;
		logic [FlagW-1:0] flags;
	} alu_outcome_t;

	// predicts each accepted operation and checks the results in order
	class alu_scoreboard;
		alu_outcome_t pending_q[$];
		int unsigned  error_count = 0;

		task report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
			$display("%0t mismatch in %s: got %h, want %h", $realtime, what, got, want);
			error_count++;
		endtask

		function int unsigned pending();
			return pending_q.size();
		endfunction

		// works out result and nzcv for one accepted operation
		function void note_operation(logic [OpW-1:0] op, logic [WordW-1:0] a,
				logic [WordW-1:0] b, logic [FlagW-1:0] fin, logic sc);
			logic [WordW:0]   sum;
			logic [WordW-1:0] val;
			logic [WordW-1:0] x;
			logic [WordW-1:0] y;
			logic             cin;
			logic             logical;
			alu_outcome_t     outcome;

			logical = 1'b1;
			val = '0;
			x = a;
			y = b;
			cin = 1'b0;
			case (op)
				OP_AND, OP_TST: val = a & b;
				OP_EOR, OP_TEQ: val = a ^ b;
				OP_ORR:         val = a | b;
				OP_MOV:         val = b;
				OP_BIC:         val = a & ~b;
				OP_MVN:         val = ~b;
				OP_SUB, OP_CMP: begin
					logical = 1'b0; y = ~b; cin = 1'b1;
				end
				OP_RSB: begin
					logical = 1'b0; x = b; y = ~a; cin = 1'b1;
				end
				OP_ADD, OP_CMN: logical = 1'b0;
				OP_ADC: begin
					logical = 1'b0; cin = fin[FLAG_C];
				end
				OP_SBC: begin
					logical = 1'b0; y = ~b; cin = fin[FLAG_C];
				end
				default: begin
					// rsc: b - a - not c
					logical = 1'b0; x = b; y = ~a; cin = fin[FLAG_C];
				end
			endcase

			if (logical) begin
				outcome.flags = {val[WordW-1], val == '0, sc, fin[FLAG_V]};
			end else begin
				sum = {1'b0, x} + {1'b0, y} + {{WordW{1'b0}}, cin};
				val = sum[WordW-1:0];
				outcome.flags = {val[WordW-1], val == '0, sum[WordW],
					(x[WordW-1] ^ val[WordW-1]) & (y[WordW-1] ^ val[WordW-1])};
			end

			// tests and compares only move the flags
			if (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN)
				outcome.result = '0;
			else
				outcome.result = val;
			pending_q.push_back(outcome);
		endfunction

		task check_result(logic [39:0] data);
			alu_outcome_t want;

			if (pending_q.size() == 0) begin
				report("result with nothing pending", data[31:0], '0);
				return;
			end
			want = pending_q.pop_front();
			if (data[31:0] !== want.result)
				report("result", data[31:0], want.result);
			if (data[35:32] !== want.flags)
				report("flags", {28'd0, data[35:32]}, {28'd0, want.flags});
			if (data[39:36] !== 4'd0)
				report("tdata padding", {28'd0, data[39:36]}, '0);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [3:0]  s_tuser;  // [3:0] operation
	// [31:0] operand_n, [63:32] operand_shifted, [67:64] flags_in,
	// [68] shifter_carry, [71:69] zero
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // [31:0] result, [35:32] flags_out, [39:36] zero

	alu_scoreboard board;
	int unsigned   cycle_count;

	// idling controls shared between the sender, the receiver and the sequence
	logic tx_calm;
	logic rx_calm;
	logic choke_req;

	arm_data_processing_alu i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("arm_data_processing_alu_tb: done, errors");
			$finish;
		end
	end

	// output monitor: sampled before the edge updates the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// receiver: random stalls per transfer, plus a long hold-off on request
	initial begin
		int unsigned stall;

		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (choke_req) begin
				choke_req = 1'b0;
				m_tready = 1'b0;
				repeat (ChokeCycles) @(negedge clk);
			end
			stall = rx_calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// offers one operation and waits for its transfer
	task send_op(logic [OpW-1:0] op, logic [WordW-1:0] a, logic [WordW-1:0] b,
			logic [FlagW-1:0] fin, logic sc);
		int unsigned gap;

		gap = tx_calm ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = op;
		s_tdata  = {3'b000, sc, fin, b, a};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_operation(op, a, b, fin, sc);
	endtask

	// operands leaning toward the corners of the adder
	function logic [WordW-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	task send_random();
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;

		a = pick_word();
		// equal operands hit the zero result of sub and eor often
		b = ($urandom_range(0, 7) == 0) ? a : pick_word();
		send_op(OpW'($urandom_range(0, 15)), a, b, FlagW'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)));
	endtask

	initial begin
		board     = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = '0;
		s_tdata   = '0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		choke_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: carry, overflow, borrow and zero corners, every opcode sent at least once
		send_op(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 4'b0000, 1'b0);
		send_op(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 4'b0000, 1'b0);
		send_op(OP_ADC, 32'hFFFF_FFFF, 32'h0000_0000, 4'b0010, 1'b0);
		send_op(OP_ADC, 32'h7FFF_FFFF, 32'h0000_0000, 4'b0010, 1'b0);
		send_op(OP_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1101, 1'b1);
		send_op(OP_SUB, 32'h1234_5678, 32'h1234_5678, 4'b0000, 1'b0);
		send_op(OP_SUB, 32'h0000_0000, 32'h0000_0001, 4'b0000, 1'b0);
		send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001, 4'b0000, 1'b0);
		send_op(OP_RSB, 32'h0000_0001, 32'h0000_0000, 4'b0000, 1'b0);
		send_op(OP_SBC, 32'h0000_0005, 32'h0000_0005, 4'b0000, 1'b0);
		send_op(OP_SBC, 32'h0000_0005, 32'h0000_0005, 4'b0010, 1'b0);
		send_op(OP_RSC, 32'h0000_0000, 32'h8000_0000, 4'b0000, 1'b0);
		send_op(OP_RSC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b0010, 1'b0);
		send_op(OP_CMP, 32'h0000_0003, 32'h0000_0003, 4'b0000, 1'b0);
		send_op(OP_CMN, 32'h8000_0000, 32'h8000_0000, 4'b0000, 1'b0);
		send_op(OP_TST, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 4'b0001, 1'b1);
		send_op(OP_TEQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 4'b1110, 1'b0);
		send_op(OP_AND, 32'hFFFF_FFFF, 32'h8000_0000, 4'b0001, 1'b0);
		send_op(OP_EOR, 32'hAAAA_AAAA, 32'h5555_5555, 4'b0000, 1'b1);
		// orr, mov, bic and mvn take n from the value itself
		send_op(OP_ORR, 32'h0000_0001, 32'h8000_0000, 4'b0000, 1'b0);
		send_op(OP_ORR, 32'h8000_0000, 32'h0000_0000, 4'b1111, 1'b1);
		send_op(OP_MOV, 32'hFFFF_FFFF, 32'h0000_0000, 4'b1011, 1'b1);
		send_op(OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b0001, 1'b0);
		send_op(OP_MVN, 32'h0000_0000, 32'h0000_0000, 4'b0000, 1'b1);
		send_op(OP_MVN, 32'h0000_0000, 32'hFFFF_FFFF, 4'b1111, 1'b0);

		for (int unsigned i = 0; i < RandomItems; i++) begin
			if (i == 200) begin
				// back-to-back offers against a long receiver hold-off
				tx_calm   = 1'b1;
				choke_req = 1'b1;
			end else if (i == 230) begin
				// let the pipe drain completely, then run with no idling
				@(negedge clk);
				s_tvalid = 1'b0;
				while (board.pending() != 0) @(posedge clk);
				rx_calm = 1'b1;
			end else if (i == 360) begin
				tx_calm = 1'b0;
				rx_calm = 1'b0;
			end
			send_random();
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (board.error_count == 0)
			$display("arm_data_processing_alu_tb: done, clean");
		else
			$display("arm_data_processing_alu_tb: done, errors");
		$finish;
	end

endmodule

### arm_data_processing_alu.f
rtl/dpalu_pkg.sv
rtl/dpalu_operand.sv
rtl/dpalu_exec.sv
rtl/dpalu_flags.sv
rtl/arm_data_processing_alu.sv
rtl/dpalu_checker.sv
test/arm_data_processing_alu_tb.sv
